FILE: design/bcdc_pkg.sv
// Package for the BCD calculator processor step block.
// Holds widths, opcode codes, control types and the arithmetic decode table.
// Used by bcdc_digit_alu and bcd_calculator_processor_step.
package bcdc_pkg;

    localparam int DIGITS      = 14;
    localparam int REG_W       = 4 * DIGITS;
    localparam int TOP_DIGIT   = DIGITS - 1;
    localparam int STORE_WORDS_DEF = 10;
    localparam int NUM_REGS    = 7;
    localparam int NUM_FLAGS   = 12;

    // Working register indexes.
    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_C = 3'd2;
    localparam logic [2:0] REG_D = 3'd3;
    localparam logic [2:0] REG_E = 3'd4;
    localparam logic [2:0] REG_F = 3'd5;
    localparam logic [2:0] REG_M = 3'd6;

    // Word types in the two low bits of an instruction.
    localparam logic [1:0] WT_MISC   = 2'd0;
    localparam logic [1:0] WT_CALL   = 2'd1;
    localparam logic [1:0] WT_ARITH  = 2'd2;
    localparam logic [1:0] WT_BRANCH = 2'd3;

    // Groups of type 0 words in bits 3:2.
    localparam logic [1:0] GRP_MISC    = 2'd0;
    localparam logic [1:0] GRP_FLAGS   = 2'd1;
    localparam logic [1:0] GRP_DATA    = 2'd2;
    localparam logic [1:0] GRP_POINTER = 2'd3;

    // Flag group operations.
    localparam logic [1:0] FOP_SET   = 2'd0;
    localparam logic [1:0] FOP_TEST  = 2'd1;
    localparam logic [1:0] FOP_CLEAR = 2'd2;
    localparam logic [1:0] FOP_CLALL = 2'd3;

    // Pointer group operations.
    localparam logic [1:0] POP_LOAD = 2'd0;
    localparam logic [1:0] POP_DEC  = 2'd1;
    localparam logic [1:0] POP_TEST = 2'd2;
    localparam logic [1:0] POP_INC  = 2'd3;

    // Data group operations.
    localparam logic [1:0] DOP_UNUSED = 2'd0;
    localparam logic [1:0] DOP_CONST  = 2'd1;

    // Data group register moves, selected by the number field.
    localparam logic [3:0] DN_DISP_TOGGLE = 4'd0;
    localparam logic [3:0] DN_SWAP_CM     = 4'd2;
    localparam logic [3:0] DN_PUSH        = 4'd4;
    localparam logic [3:0] DN_POP         = 4'd6;
    localparam logic [3:0] DN_DISP_OFF    = 4'd8;
    localparam logic [3:0] DN_RECALL_M    = 4'd10;
    localparam logic [3:0] DN_LOAD_STORE  = 4'd11;
    localparam logic [3:0] DN_ROTATE      = 4'd12;
    localparam logic [3:0] DN_CLEAR_ALL   = 4'd14;

    // Misc group operations in bits 6:5 when bit 4 is set.
    localparam logic [1:0] MOP_ROM_SEL  = 2'd0;
    localparam logic [1:0] MOP_RETURN   = 2'd1;
    localparam logic [1:0] MOP_KEY_JUMP = 2'd2;
    localparam logic [1:0] MOP_STORE    = 2'd3;
    localparam logic [2:0] MN_STORE_WR  = 3'h5;

    // Word-select codes.
    localparam logic [2:0] WS_POINTER = 3'd0;
    localparam logic [2:0] WS_MANT    = 3'd1;
    localparam logic [2:0] WS_EXP     = 3'd2;
    localparam logic [2:0] WS_WORD    = 3'd3;
    localparam logic [2:0] WS_UPTO_P  = 3'd4;
    localparam logic [2:0] WS_MANT_S  = 3'd5;
    localparam logic [2:0] WS_EXP_S   = 3'd6;
    localparam logic [2:0] WS_SIGN    = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIGIT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        K_MOVE,
        K_EXCH,
        K_SHL,
        K_SHR,
        K_ADD,
        K_SUB,
        K_NEG9,
        K_GE,
        K_NZ
    } kind_t;

    typedef enum logic [2:0] {
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_ZERO,
        SRC_ONE
    } src_t;

    typedef struct packed {
        kind_t      kind;
        src_t       x;
        src_t       y;
        logic [2:0] dst;
        logic [2:0] dst2;
    } arith_ctl_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] x;
        logic [3:0] y;
        logic       cy;
        logic       aux;
        logic       first;
    } alu_in_t;

    typedef struct packed {
        logic [3:0] res;
        logic       wr;
        logic       carry;
        logic       aux;
    } alu_out_t;

    // Register operation decode, indexed by bits 9:5 of an arithmetic word.
    localparam arith_ctl_t ARITH_TABLE [32] = '{
        '{K_NZ,   SRC_B,    SRC_ZERO, REG_A, REG_A},  // test B nonzero
        '{K_MOVE, SRC_ZERO, SRC_ZERO, REG_B, REG_B},  // B = 0
        '{K_GE,   SRC_A,    SRC_C,    REG_A, REG_A},  // A >= C
        '{K_GE,   SRC_C,    SRC_ONE,  REG_A, REG_A},  // C >= 1
        '{K_MOVE, SRC_ZERO, SRC_B,    REG_C, REG_C},  // C = B
        '{K_SUB,  SRC_ZERO, SRC_C,    REG_C, REG_C},  // C = 0 - C
        '{K_MOVE, SRC_ZERO, SRC_ZERO, REG_C, REG_C},  // C = 0
        '{K_NEG9, SRC_ZERO, SRC_C,    REG_C, REG_C},  // C = 0 - C - 1
        '{K_SHL,  SRC_A,    SRC_ZERO, REG_A, REG_A},  // shift A left
        '{K_MOVE, SRC_ZERO, SRC_A,    REG_B, REG_B},  // B = A
        '{K_SUB,  SRC_A,    SRC_C,    REG_C, REG_C},  // C = A - C
        '{K_SUB,  SRC_C,    SRC_ONE,  REG_C, REG_C},  // C = C - 1
        '{K_MOVE, SRC_ZERO, SRC_C,    REG_A, REG_A},  // A = C
        '{K_NZ,   SRC_C,    SRC_ZERO, REG_A, REG_A},  // test C nonzero
        '{K_ADD,  SRC_A,    SRC_C,    REG_C, REG_C},  // C = A + C
        '{K_ADD,  SRC_C,    SRC_ONE,  REG_C, REG_C},  // C = C + 1
        '{K_GE,   SRC_A,    SRC_B,    REG_A, REG_A},  // A >= B
        '{K_EXCH, SRC_B,    SRC_C,    REG_B, REG_C},  // B <-> C
        '{K_SHR,  SRC_C,    SRC_ZERO, REG_C, REG_C},  // shift C right
        '{K_GE,   SRC_A,    SRC_ONE,  REG_A, REG_A},  // A >= 1
        '{K_SHR,  SRC_B,    SRC_ZERO, REG_B, REG_B},  // shift B right
        '{K_ADD,  SRC_C,    SRC_C,    REG_C, REG_C},  // C = C + C
        '{K_SHR,  SRC_A,    SRC_ZERO, REG_A, REG_A},  // shift A right
        '{K_MOVE, SRC_ZERO, SRC_ZERO, REG_A, REG_A},  // A = 0
        '{K_SUB,  SRC_A,    SRC_B,    REG_A, REG_A},  // A = A - B
        '{K_EXCH, SRC_A,    SRC_B,    REG_A, REG_B},  // A <-> B
        '{K_SUB,  SRC_A,    SRC_C,    REG_A, REG_A},  // A = A - C
        '{K_SUB,  SRC_A,    SRC_ONE,  REG_A, REG_A},  // A = A - 1
        '{K_ADD,  SRC_A,    SRC_B,    REG_A, REG_A},  // A = A + B
        '{K_EXCH, SRC_A,    SRC_C,    REG_A, REG_C},  // A <-> C
        '{K_ADD,  SRC_A,    SRC_C,    REG_A, REG_A},  // A = A + C
        '{K_ADD,  SRC_A,    SRC_ONE,  REG_A, REG_A}   // A = A + 1
    };

    // Read one digit of a register; digits past the top read as zero.
    function automatic logic [3:0] get_dig(logic [REG_W-1:0] r, logic [3:0] i);
        logic [3:0] d;
        d = 4'd0;
        for (int j = 0; j < DIGITS; j++) begin
            if (i == 4'(j)) begin
                d = r[4*j +: 4];
            end
        end
        return d;
    endfunction

    // Replace one digit of a register; digits past the top are dropped.
    function automatic logic [REG_W-1:0] put_dig(logic [REG_W-1:0] r, logic [3:0] i,
                                                 logic [3:0] v);
        logic [REG_W-1:0] q;
        q = r;
        for (int j = 0; j < DIGITS; j++) begin
            if (i == 4'(j)) begin
                q[4*j +: 4] = v;
            end
        end
        return q;
    endfunction

endpackage

FILE: design/bcd_calculator_processor_step.sv
// BCD calculator processor step: executes one instruction word per item.
// Flag, pointer, data and jump words pass from accept through the execute and done states;
// register operations also walk the word-select field (1 to 14 digits) digit by digit
// in the digit-serial BCD unit. One item is in work at a time.
// Reset (aresetn low, synchronous) clears all registers, the store and the flags.
// Depends on bcdc_pkg and bcdc_digit_alu.
module bcd_calculator_processor_step
    import bcdc_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [9:0]        s_instruction,
    input  logic              s_key_pressed,
    input  logic [7:0]        s_key_code,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [10:0]       m_fetch_address,
    output logic              m_carry_flag,
    output logic              m_display_enabled,
    output logic [REG_W-1:0]  m_reg_a_digits,
    output logic [REG_W-1:0]  m_reg_b_digits,
    output logic              m_status
);

    localparam int SAW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    state_t                 state_reg, state_next;
    logic [9:0]             inst_reg, inst_next;
    logic                   key_reg, key_next;
    logic [7:0]             code_reg, code_next;
    logic [REG_W-1:0]       wr_reg [NUM_REGS];
    logic [REG_W-1:0]       wr_next [NUM_REGS];
    logic [REG_W-1:0]       ds_reg [STORE_WORDS];
    logic [REG_W-1:0]       ds_next [STORE_WORDS];
    logic [3:0]             dp_reg, dp_next;
    logic [NUM_FLAGS-1:0]   flags_reg, flags_next;
    logic                   carry_reg, carry_next;
    logic                   chain_reg, chain_next;
    logic [10:0]            pc_reg, pc_next;
    logic [7:0]             ret_reg, ret_next;
    logic [3:0]             sa_reg, sa_next;
    logic                   disp_reg, disp_next;
    logic                   bad_reg, bad_next;
    logic [3:0]             lo_reg, lo_next;
    logic [3:0]             hi_reg, hi_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [10:0]            o_pc_reg;
    logic                   o_carry_reg;
    logic                   o_disp_reg;
    logic [REG_W-1:0]       o_a_reg;
    logic [REG_W-1:0]       o_b_reg;
    logic                   o_bad_reg;
    logic                   load_out;

    arith_ctl_t             actl;
    alu_in_t                alu_in;
    alu_out_t               alu_out;
    logic [3:0]             dig_idx;
    logic [REG_W-1:0]       x_reg_val;
    logic [REG_W-1:0]       y_reg_val;
    logic [3:0]             dp_clip;
    logic [10:0]            pc_inc;
    logic                   sa_ok;
    logic                   last_dig;

    assign actl     = ARITH_TABLE[inst_reg[9:5]];
    assign dp_clip  = (dp_reg > 4'(TOP_DIGIT)) ? 4'(TOP_DIGIT) : dp_reg;
    assign pc_inc   = {pc_reg[10:8], pc_reg[7:0] + 8'd1};
    assign sa_ok    = ({1'b0, sa_reg} < 5'(STORE_WORDS));
    assign dig_idx  = (actl.kind == K_SHL) ? (hi_reg - cnt_reg) : (lo_reg + cnt_reg);
    assign last_dig = (cnt_reg == (hi_reg - lo_reg));

    // Register sources of the digit unit.
    always_comb begin
        unique case (actl.x)
            SRC_A:   x_reg_val = wr_reg[REG_A];
            SRC_B:   x_reg_val = wr_reg[REG_B];
            SRC_C:   x_reg_val = wr_reg[REG_C];
            default: x_reg_val = '0;
        endcase
        unique case (actl.y)
            SRC_A:   y_reg_val = wr_reg[REG_A];
            SRC_B:   y_reg_val = wr_reg[REG_B];
            SRC_C:   y_reg_val = wr_reg[REG_C];
            default: y_reg_val = '0;
        endcase
    end

    // Operand digits for the current position of the field.
    always_comb begin
        alu_in.kind  = actl.kind;
        alu_in.cy    = carry_reg;
        alu_in.aux   = chain_reg;
        alu_in.first = (dig_idx == lo_reg);
        alu_in.x     = get_dig(x_reg_val, dig_idx);
        unique case (actl.kind)
            K_SHL:   alu_in.y = (dig_idx == lo_reg) ? 4'd0 :
                                get_dig(x_reg_val, dig_idx - 4'd1);
            K_SHR:   alu_in.y = (dig_idx == hi_reg) ? 4'd0 :
                                get_dig(x_reg_val, dig_idx + 4'd1);
            default: begin
                if (actl.y == SRC_ONE) begin
                    alu_in.y = {3'd0, dig_idx == lo_reg};
                end else begin
                    alu_in.y = get_dig(y_reg_val, dig_idx);
                end
            end
        endcase
    end

    bcdc_digit_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    // Next state and execution of the instruction word.
    always_comb begin
        state_next   = state_reg;
        inst_next    = inst_reg;
        key_next     = key_reg;
        code_next    = code_reg;
        wr_next      = wr_reg;
        ds_next      = ds_reg;
        dp_next      = dp_reg;
        flags_next   = flags_reg;
        carry_next   = carry_reg;
        chain_next   = chain_reg;
        pc_next      = pc_reg;
        ret_next     = ret_reg;
        sa_next      = sa_reg;
        disp_next    = disp_reg;
        bad_next     = bad_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        cnt_next     = cnt_reg;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    inst_next  = s_instruction;
                    key_next   = s_key_pressed;
                    code_next  = s_key_code;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Common prologue: address advance within the page, key flag, carry clear.
                pc_next       = pc_inc;
                flags_next    = {flags_reg[NUM_FLAGS-1:1], key_reg};
                carry_next    = 1'b0;
                bad_next      = 1'b0;
                state_next    = ST_DONE;
                unique case (inst_reg[1:0])
                    WT_MISC: begin
                        unique case (inst_reg[3:2])
                            GRP_MISC: begin
                                if (inst_reg[4]) begin
                                    unique case (inst_reg[6:5])
                                        MOP_ROM_SEL: pc_next = {inst_reg[9:7], pc_inc[7:0]};
                                        MOP_RETURN:  pc_next = {pc_inc[10:8], ret_reg};
                                        MOP_KEY_JUMP: begin
                                            if (!inst_reg[7]) begin
                                                bad_next = 1'b1;
                                            end else begin
                                                pc_next = {pc_inc[10:8], code_reg};
                                            end
                                        end
                                        default: begin
                                            if (inst_reg[9] && !inst_reg[7]) begin
                                                sa_next = get_dig(wr_reg[REG_C], 4'd12);
                                            end else if (inst_reg[9:7] == MN_STORE_WR) begin
                                                for (int w = 0; w < STORE_WORDS; w++) begin
                                                    if (sa_ok && sa_reg[SAW-1:0] == SAW'(w)) begin
                                                        ds_next[w] = wr_reg[REG_C];
                                                    end
                                                end
                                            end else begin
                                                bad_next = 1'b1;
                                            end
                                        end
                                    endcase
                                end else begin
                                    bad_next = (inst_reg[9:2] != 8'd0);
                                end
                            end
                            GRP_FLAGS: begin
                                unique case (inst_reg[5:4])
                                    FOP_SET: begin
                                        if (inst_reg[9:6] >= 4'(NUM_FLAGS)) begin
                                            bad_next = 1'b1;
                                        end else begin
                                            flags_next[inst_reg[9:6]] = 1'b1;
                                        end
                                    end
                                    FOP_TEST: begin
                                        if (inst_reg[9:6] >= 4'(NUM_FLAGS)) begin
                                            bad_next = 1'b1;
                                        end else begin
                                            carry_next = flags_next[inst_reg[9:6]];
                                        end
                                    end
                                    FOP_CLEAR: begin
                                        if (inst_reg[9:6] >= 4'(NUM_FLAGS)) begin
                                            bad_next = 1'b1;
                                        end else begin
                                            flags_next[inst_reg[9:6]] = 1'b0;
                                        end
                                    end
                                    default: begin
                                        if (inst_reg[9:6] != 4'd0) begin
                                            bad_next = 1'b1;
                                        end else begin
                                            flags_next = '0;
                                        end
                                    end
                                endcase
                            end
                            GRP_DATA: begin
                                if (inst_reg[5:4] == DOP_UNUSED) begin
                                    bad_next = 1'b1;
                                end else if (inst_reg[5:4] == DOP_CONST) begin
                                    if (inst_reg[9:6] >= 4'd10) begin
                                        bad_next = 1'b1;
                                    end else begin
                                        wr_next[REG_C] = put_dig(wr_reg[REG_C], dp_reg,
                                                                 inst_reg[9:6]);
                                        dp_next = dp_reg - 4'd1;
                                    end
                                end else begin
                                    unique case (inst_reg[9:6])
                                        DN_DISP_TOGGLE: disp_next = !disp_reg;
                                        DN_SWAP_CM: begin
                                            wr_next[REG_C] = wr_reg[REG_M];
                                            wr_next[REG_M] = wr_reg[REG_C];
                                        end
                                        DN_PUSH: begin
                                            wr_next[REG_F] = wr_reg[REG_E];
                                            wr_next[REG_E] = wr_reg[REG_D];
                                            wr_next[REG_D] = wr_reg[REG_C];
                                        end
                                        DN_POP: begin
                                            wr_next[REG_A] = wr_reg[REG_D];
                                            wr_next[REG_D] = wr_reg[REG_E];
                                            wr_next[REG_E] = wr_reg[REG_F];
                                        end
                                        DN_DISP_OFF: disp_next = 1'b0;
                                        DN_RECALL_M: wr_next[REG_C] = wr_reg[REG_M];
                                        DN_LOAD_STORE: begin
                                            if (sa_ok) begin
                                                wr_next[REG_C] = ds_reg[sa_reg[SAW-1:0]];
                                            end
                                        end
                                        DN_ROTATE: begin
                                            wr_next[REG_C] = wr_reg[REG_D];
                                            wr_next[REG_D] = wr_reg[REG_E];
                                            wr_next[REG_E] = wr_reg[REG_F];
                                            wr_next[REG_F] = wr_reg[REG_C];
                                        end
                                        DN_CLEAR_ALL: begin
                                            for (int r = 0; r < NUM_REGS; r++) begin
                                                wr_next[r] = '0;
                                            end
                                        end
                                        default: bad_next = 1'b1;
                                    endcase
                                end
                            end
                            default: begin
                                unique case (inst_reg[5:4])
                                    POP_LOAD: dp_next    = inst_reg[9:6];
                                    POP_TEST: carry_next = (dp_reg == inst_reg[9:6]);
                                    POP_DEC:  dp_next    = dp_reg - 4'd1;
                                    default:  dp_next    = dp_reg + 4'd1;
                                endcase
                            end
                        endcase
                    end
                    WT_CALL: begin
                        ret_next = pc_inc[7:0];
                        pc_next  = {pc_inc[10:8], inst_reg[9:2]};
                    end
                    WT_ARITH: begin
                        // Set up the digit field and walk it in the digit state.
                        cnt_next   = 4'd0;
                        chain_next = 1'b0;
                        state_next = ST_DIGIT;
                        unique case (inst_reg[4:2])
                            WS_POINTER: begin lo_next = dp_clip; hi_next = dp_clip; end
                            WS_MANT:    begin lo_next = 4'd3; hi_next = 4'd12; end
                            WS_EXP:     begin lo_next = 4'd0; hi_next = 4'd2; end
                            WS_WORD:    begin lo_next = 4'd0; hi_next = 4'(TOP_DIGIT); end
                            WS_UPTO_P:  begin lo_next = 4'd0; hi_next = dp_clip; end
                            WS_MANT_S:  begin lo_next = 4'd3; hi_next = 4'(TOP_DIGIT); end
                            WS_EXP_S:   begin lo_next = 4'd2; hi_next = 4'd2; end
                            default: begin
                                lo_next = 4'(TOP_DIGIT);
                                hi_next = 4'(TOP_DIGIT);
                            end
                        endcase
                    end
                    default: begin
                        if (!carry_reg) begin
                            pc_next = {pc_inc[10:8], inst_reg[9:2]};
                        end
                    end
                endcase
            end
            ST_DIGIT: begin
                // One digit of the field per cycle.
                if (alu_out.wr) begin
                    wr_next[actl.dst] = put_dig(wr_reg[actl.dst], dig_idx, alu_out.res);
                end
                if (actl.kind == K_EXCH) begin
                    wr_next[actl.dst2] = put_dig(wr_reg[actl.dst2], dig_idx, alu_in.x);
                end
                carry_next = alu_out.carry;
                chain_next = alu_out.aux;
                cnt_next   = cnt_reg + 4'd1;
                if (last_dig) begin
                    state_next = ST_DONE;
                end
            end
            default: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dp_reg      <= '0;
            flags_reg   <= '0;
            carry_reg   <= 1'b0;
            chain_reg   <= 1'b0;
            pc_reg      <= '0;
            ret_reg     <= '0;
            sa_reg      <= '0;
            disp_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int r = 0; r < NUM_REGS; r++) begin
                wr_reg[r] <= '0;
            end
            for (int w = 0; w < STORE_WORDS; w++) begin
                ds_reg[w] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            dp_reg      <= dp_next;
            flags_reg   <= flags_next;
            carry_reg   <= carry_next;
            chain_reg   <= chain_next;
            pc_reg      <= pc_next;
            ret_reg     <= ret_next;
            sa_reg      <= sa_next;
            disp_reg    <= disp_next;
            bad_reg     <= bad_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            wr_reg      <= wr_next;
            ds_reg      <= ds_next;
        end
    end

    // Captured input item and result item payload.
    always_ff @(posedge aclk) begin
        inst_reg <= inst_next;
        key_reg  <= key_next;
        code_reg <= code_next;
        if (load_out) begin
            o_pc_reg    <= pc_reg;
            o_carry_reg <= carry_reg;
            o_disp_reg  <= disp_reg;
            o_a_reg     <= wr_reg[REG_A];
            o_b_reg     <= wr_reg[REG_B];
            o_bad_reg   <= bad_reg;
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_fetch_address   = o_pc_reg;
    assign m_carry_flag      = o_carry_reg;
    assign m_display_enabled = o_disp_reg;
    assign m_reg_a_digits    = o_a_reg;
    assign m_reg_b_digits    = o_b_reg;
    assign m_status          = o_bad_reg;

    // The digit walk never runs past the end of its field.
    a_field_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT) |-> (lo_reg <= hi_reg) && (hi_reg <= 4'(TOP_DIGIT))
                                    && (cnt_reg <= (hi_reg - lo_reg)))
        else $error("digit walk outside its field");

    // A new result item appears only from the completion state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result item raised outside completion");

    // An item is taken only while no instruction is in work, and moves the block into the execute state.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not start execution");

endmodule

FILE: design/bcdc_digit_alu.sv
// One-digit BCD unit for the calculator processor step block.
// Adds, subtracts, compares and tests one digit per cycle; depends on bcdc_pkg.
module bcdc_digit_alu
    import bcdc_pkg::*;
(
    input  alu_in_t  alu_in,
    output alu_out_t alu_out
);

    logic [4:0] sum;
    logic [5:0] diff;
    logic [5:0] diff1;
    logic [3:0] d1;
    logic [5:0] diff2;

    // Digit sums and differences with decimal correction.
    always_comb begin
        sum   = 5'(alu_in.x) + 5'(alu_in.y) + 5'(alu_in.cy);
        diff  = 6'(alu_in.x) - 6'(alu_in.y) - 6'(alu_in.cy);
        diff1 = 6'(alu_in.x) - 6'(alu_in.y) - 6'(alu_in.aux);
        d1    = diff1[5] ? 4'(diff1 + 6'd10) : diff1[3:0];
        diff2 = 6'(d1) - 6'(alu_in.first) - 6'(alu_in.cy);
    end

    // Result digit and carries by operation kind.
    always_comb begin
        alu_out.res   = alu_in.y;
        alu_out.wr    = 1'b0;
        alu_out.carry = alu_in.cy;
        alu_out.aux   = alu_in.aux;
        unique case (alu_in.kind)
            K_MOVE, K_EXCH, K_SHL, K_SHR: begin
                alu_out.wr = 1'b1;
            end
            K_ADD: begin
                alu_out.wr    = 1'b1;
                alu_out.carry = (sum >= 5'd10);
                alu_out.res   = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
            end
            K_SUB: begin
                alu_out.wr    = 1'b1;
                alu_out.carry = diff[5];
                alu_out.res   = diff[5] ? 4'(diff + 6'd10) : diff[3:0];
            end
            K_NEG9: begin
                // Negate with the auxiliary borrow, then take one off the low digit.
                alu_out.wr    = 1'b1;
                alu_out.aux   = diff1[5];
                alu_out.carry = diff2[5];
                alu_out.res   = diff2[5] ? 4'(diff2 + 6'd10) : diff2[3:0];
            end
            K_GE: begin
                if (alu_in.x > alu_in.y) begin
                    alu_out.carry = 1'b0;
                end else if (alu_in.x < alu_in.y) begin
                    alu_out.carry = 1'b1;
                end
            end
            K_NZ: begin
                alu_out.carry = alu_in.cy | (alu_in.x != 4'd0);
            end
            default: begin
                alu_out.wr = 1'b0;
            end
        endcase
    end

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for bcd_calculator_processor_step.
// Drives instruction items with random idling, predicts every result in place and
// checks it field by field; depends on bcdc_pkg and the block's RTL only.
module tb_top;
    import bcdc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 500;
    localparam int STORE_SIZE   = STORE_WORDS_DEF;

    // Register operation codes, bits 9:5 of a type 2 word.
    typedef enum logic [4:0] {
        AR_TST_B_NZ, AR_CLR_B, AR_GE_A_C, AR_GE_C_1, AR_MOV_C_B, AR_NEG_C, AR_CLR_C,
        AR_NEG9_C, AR_SHL_A, AR_MOV_B_A, AR_C_A_MINUS_C, AR_DEC_C, AR_MOV_A_C,
        AR_TST_C_NZ, AR_C_A_PLUS_C, AR_INC_C, AR_GE_A_B, AR_XCH_B_C, AR_SHR_C,
        AR_GE_A_1, AR_SHR_B, AR_DBL_C, AR_SHR_A, AR_CLR_A, AR_SUB_A_B, AR_XCH_A_B,
        AR_SUB_A_C, AR_DEC_A, AR_ADD_A_B, AR_XCH_A_C, AR_ADD_A_C, AR_INC_A
    } arith_op_t;

    typedef struct {
        logic [10:0]      fetch;
        logic             carry;
        logic             disp;
        logic [REG_W-1:0] reg_a;
        logic [REG_W-1:0] reg_b;
        logic             status;
    } outcome_t;

    typedef struct {
        logic [9:0] word;
        logic       key;
        logic [7:0] code;
        bit         typed;
        logic [10:0] t_fetch;
        logic       t_status;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [9:0] s_instruction = '0;
    logic s_key_pressed = 1'b0;
    logic [7:0] s_key_code = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [10:0] m_fetch_address;
    logic m_carry_flag;
    logic m_display_enabled;
    logic [REG_W-1:0] m_reg_a_digits;
    logic [REG_W-1:0] m_reg_b_digits;
    logic m_status;

    // Processor state as the predictor sees it.
    logic [REG_W-1:0] regs [NUM_REGS];
    logic [REG_W-1:0] store [STORE_SIZE];
    logic [3:0]  ptr;
    logic [11:0] flags;
    logic        cy;
    logic [10:0] pc;
    logic [7:0]  ret_addr;
    logic [3:0]  store_addr;
    logic        disp_on;

    outcome_t  pending_results [$];
    stim_row_t directed [$];
    int  mismatches = 0;
    int  cycles = 0;
    int  results_seen = 0;
    bit  stimulus_done = 1'b0;

    bcd_calculator_processor_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_instruction(s_instruction),
        .s_key_pressed(s_key_pressed), .s_key_code(s_key_code),
        .m_valid(m_valid), .m_ready(m_ready), .m_fetch_address(m_fetch_address),
        .m_carry_flag(m_carry_flag), .m_display_enabled(m_display_enabled),
        .m_reg_a_digits(m_reg_a_digits), .m_reg_b_digits(m_reg_b_digits),
        .m_status(m_status)
    );

    always #5 aclk = ~aclk;

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [3:0] dg(logic [REG_W-1:0] r, int i);
        return r[4*i +: 4];
    endfunction

    function automatic int clip13(logic [3:0] d);
        return (d > TOP_DIGIT) ? TOP_DIGIT : int'(d);
    endfunction

    function automatic logic [REG_W-1:0] field_move(logic [REG_W-1:0] dst,
                                                   logic [REG_W-1:0] src, int lo, int hi);
        for (int i = lo; i <= hi; i++) dst[4*i +: 4] = src[4*i +: 4];
        return dst;
    endfunction

    // Digit-serial BCD add or subtract over the field, carry out is the last carry or borrow.
    function automatic logic [REG_W-1:0] field_sum(logic [REG_W-1:0] x, logic [REG_W-1:0] y,
                                                  logic [REG_W-1:0] z, bit sub, int lo,
                                                  int hi, output logic c_out);
        int c;
        int k;
        k = 0;
        for (int i = lo; i <= hi; i++) begin
            if (sub) begin
                c = int'(dg(x, i)) - int'(dg(y, i)) - k;
                if (c < 0) begin
                    k = 1;
                    c += 10;
                end else begin
                    k = 0;
                end
            end else begin
                c = int'(dg(x, i)) + int'(dg(y, i)) + k;
                if (c >= 10) begin
                    k = 1;
                    c -= 10;
                end else begin
                    k = 0;
                end
            end
            z[4*i +: 4] = c[3:0];
        end
        c_out = k[0];
        return z;
    endfunction

    function automatic logic [REG_W-1:0] field_shift(logic [REG_W-1:0] r, bit left,
                                                    int lo, int hi);
        if (left) begin
            for (int i = hi; i > lo; i--) r[4*i +: 4] = r[4*(i-1) +: 4];
            r[4*lo +: 4] = 4'd0;
        end else begin
            for (int i = lo; i < hi; i++) r[4*i +: 4] = r[4*(i+1) +: 4];
            r[4*hi +: 4] = 4'd0;
        end
        return r;
    endfunction

    // Carry is set when x is below y, comparing from the top digit of the field.
    function automatic logic field_less(logic [REG_W-1:0] x, logic [REG_W-1:0] y,
                                        int lo, int hi);
        for (int i = hi; i >= lo; i--) begin
            if (dg(x, i) > dg(y, i)) return 1'b0;
            if (dg(x, i) < dg(y, i)) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_state();
        for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
        for (int i = 0; i < STORE_SIZE; i++) store[i] = '0;
        ptr = '0;
        flags = '0;
        cy = 1'b0;
        pc = '0;
        ret_addr = '0;
        store_addr = '0;
        disp_on = 1'b0;
    endfunction

    // Register operations on a word-select field.
    function automatic void exec_register_op(logic [7:0] op);
        int lo;
        int hi;
        logic [REG_W-1:0] one;
        logic [REG_W-1:0] t;
        case (op[2:0])
            WS_POINTER: begin lo = clip13(ptr); hi = lo; end
            WS_MANT:    begin lo = 3; hi = 12; end
            WS_EXP:     begin lo = 0; hi = 2; end
            WS_WORD:    begin lo = 0; hi = TOP_DIGIT; end
            WS_UPTO_P:  begin lo = 0; hi = clip13(ptr); end
            WS_MANT_S:  begin lo = 3; hi = TOP_DIGIT; end
            WS_EXP_S:   begin lo = 2; hi = 2; end
            default:    begin lo = TOP_DIGIT; hi = TOP_DIGIT; end
        endcase
        one = '0;
        one[4*lo] = 1'b1;
        case (arith_op_t'(op[7:3]))
            AR_CLR_A:   regs[REG_A] = field_move(regs[REG_A], '0, lo, hi);
            AR_CLR_B:   regs[REG_B] = field_move(regs[REG_B], '0, lo, hi);
            AR_CLR_C:   regs[REG_C] = field_move(regs[REG_C], '0, lo, hi);
            AR_MOV_B_A: regs[REG_B] = field_move(regs[REG_B], regs[REG_A], lo, hi);
            AR_MOV_C_B: regs[REG_C] = field_move(regs[REG_C], regs[REG_B], lo, hi);
            AR_MOV_A_C: regs[REG_A] = field_move(regs[REG_A], regs[REG_C], lo, hi);
            AR_XCH_A_B: begin
                t = regs[REG_A];
                regs[REG_A] = field_move(regs[REG_A], regs[REG_B], lo, hi);
                regs[REG_B] = field_move(regs[REG_B], t, lo, hi);
            end
            AR_XCH_B_C: begin
                t = regs[REG_B];
                regs[REG_B] = field_move(regs[REG_B], regs[REG_C], lo, hi);
                regs[REG_C] = field_move(regs[REG_C], t, lo, hi);
            end
            AR_XCH_A_C: begin
                t = regs[REG_A];
                regs[REG_A] = field_move(regs[REG_A], regs[REG_C], lo, hi);
                regs[REG_C] = field_move(regs[REG_C], t, lo, hi);
            end
            AR_C_A_PLUS_C:
                regs[REG_C] = field_sum(regs[REG_A], regs[REG_C], regs[REG_C], 0, lo, hi, cy);
            AR_C_A_MINUS_C:
                regs[REG_C] = field_sum(regs[REG_A], regs[REG_C], regs[REG_C], 1, lo, hi, cy);
            AR_ADD_A_B:
                regs[REG_A] = field_sum(regs[REG_A], regs[REG_B], regs[REG_A], 0, lo, hi, cy);
            AR_SUB_A_B:
                regs[REG_A] = field_sum(regs[REG_A], regs[REG_B], regs[REG_A], 1, lo, hi, cy);
            AR_ADD_A_C:
                regs[REG_A] = field_sum(regs[REG_A], regs[REG_C], regs[REG_A], 0, lo, hi, cy);
            AR_SUB_A_C:
                regs[REG_A] = field_sum(regs[REG_A], regs[REG_C], regs[REG_A], 1, lo, hi, cy);
            AR_DBL_C:
                regs[REG_C] = field_sum(regs[REG_C], regs[REG_C], regs[REG_C], 0, lo, hi, cy);
            AR_TST_B_NZ: for (int i = lo; i <= hi; i++) if (dg(regs[REG_B], i) != 0) cy = 1'b1;
            AR_TST_C_NZ: for (int i = lo; i <= hi; i++) if (dg(regs[REG_C], i) != 0) cy = 1'b1;
            AR_GE_A_C: cy = field_less(regs[REG_A], regs[REG_C], lo, hi);
            AR_GE_A_B: cy = field_less(regs[REG_A], regs[REG_B], lo, hi);
            AR_GE_A_1: cy = field_less(regs[REG_A], one, lo, hi);
            AR_GE_C_1: cy = field_less(regs[REG_C], one, lo, hi);
            AR_NEG_C:
                regs[REG_C] = field_sum('0, regs[REG_C], regs[REG_C], 1, lo, hi, cy);
            AR_NEG9_C: begin
                regs[REG_C] = field_sum('0, regs[REG_C], regs[REG_C], 1, lo, hi, cy);
                regs[REG_C] = field_sum(regs[REG_C], one, regs[REG_C], 1, lo, hi, cy);
            end
            AR_INC_A: regs[REG_A] = field_sum(regs[REG_A], one, regs[REG_A], 0, lo, hi, cy);
            AR_INC_C: regs[REG_C] = field_sum(regs[REG_C], one, regs[REG_C], 0, lo, hi, cy);
            AR_DEC_A: regs[REG_A] = field_sum(regs[REG_A], one, regs[REG_A], 1, lo, hi, cy);
            AR_DEC_C: regs[REG_C] = field_sum(regs[REG_C], one, regs[REG_C], 1, lo, hi, cy);
            AR_SHR_A: regs[REG_A] = field_shift(regs[REG_A], 0, lo, hi);
            AR_SHR_B: regs[REG_B] = field_shift(regs[REG_B], 0, lo, hi);
            AR_SHR_C: regs[REG_C] = field_shift(regs[REG_C], 0, lo, hi);
            default:  regs[REG_A] = field_shift(regs[REG_A], 1, lo, hi);
        endcase
    endfunction

    // Type 0 words: misc, flags, data and pointer groups. Returns 1 when undefined.
    function automatic logic exec_group_op(logic [9:0] w, logic [7:0] code);
        logic [3:0] n;
        logic [2:0] mn;
        logic [REG_W-1:0] t;
        n = w[9:6];
        mn = w[9:7];
        case (w[3:2])
            GRP_MISC: begin
                if (!w[4]) return (w != '0);
                case (w[6:5])
                    MOP_ROM_SEL: pc = {mn, pc[7:0]};
                    MOP_RETURN:  pc = {pc[10:8], ret_addr};
                    MOP_KEY_JUMP: begin
                        if (!mn[0]) return 1'b1;
                        pc = {pc[10:8], code};
                    end
                    default: begin
                        if ((mn & 3'h5) == 3'h4) begin
                            store_addr = dg(regs[REG_C], 12);
                        end else if (mn == MN_STORE_WR) begin
                            if (store_addr < STORE_SIZE) store[store_addr] = regs[REG_C];
                        end else begin
                            return 1'b1;
                        end
                    end
                endcase
            end
            GRP_FLAGS: begin
                if (w[5:4] == FOP_CLALL) begin
                    if (n != 0) return 1'b1;
                    flags = '0;
                end else begin
                    if (n >= NUM_FLAGS) return 1'b1;
                    case (w[5:4])
                        FOP_SET:   flags[n] = 1'b1;
                        FOP_TEST:  if (flags[n]) cy = 1'b1;
                        default:   flags[n] = 1'b0;
                    endcase
                end
            end
            GRP_DATA: begin
                if (w[5:4] == DOP_UNUSED) return 1'b1;
                if (w[5:4] == DOP_CONST) begin
                    if (n >= 10) return 1'b1;
                    if (ptr <= TOP_DIGIT) regs[REG_C][4*ptr +: 4] = n;
                    ptr = ptr - 4'd1;
                    return 1'b0;
                end
                case (n)
                    DN_DISP_TOGGLE: disp_on = ~disp_on;
                    DN_SWAP_CM: begin
                        t = regs[REG_C];
                        regs[REG_C] = regs[REG_M];
                        regs[REG_M] = t;
                    end
                    DN_PUSH: begin
                        regs[REG_F] = regs[REG_E];
                        regs[REG_E] = regs[REG_D];
                        regs[REG_D] = regs[REG_C];
                    end
                    DN_POP: begin
                        regs[REG_A] = regs[REG_D];
                        regs[REG_D] = regs[REG_E];
                        regs[REG_E] = regs[REG_F];
                    end
                    DN_DISP_OFF: disp_on = 1'b0;
                    DN_RECALL_M: regs[REG_C] = regs[REG_M];
                    DN_LOAD_STORE: if (store_addr < STORE_SIZE) regs[REG_C] = store[store_addr];
                    DN_ROTATE: begin
                        t = regs[REG_C];
                        regs[REG_C] = regs[REG_D];
                        regs[REG_D] = regs[REG_E];
                        regs[REG_E] = regs[REG_F];
                        regs[REG_F] = t;
                    end
                    DN_CLEAR_ALL: for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
                    default: return 1'b1;
                endcase
            end
            default: begin
                case (w[5:4])
                    POP_LOAD: ptr = n;
                    POP_TEST: cy = (ptr == n);
                    POP_DEC:  ptr = ptr - 4'd1;
                    default:  ptr = ptr + 4'd1;
                endcase
            end
        endcase
        return 1'b0;
    endfunction

    // Executes one instruction word on the predicted state and returns what it reports.
    function automatic outcome_t execute_word(logic [9:0] w, logic key, logic [7:0] code);
        outcome_t o;
        logic bad;
        bad = 1'b0;
        pc = {pc[10:8], pc[7:0] + 8'd1};
        flags[0] = key;
        case (w[1:0])
            WT_MISC: begin
                cy = 1'b0;
                bad = exec_group_op(w, code);
            end
            WT_CALL: begin
                ret_addr = pc[7:0];
                pc = {pc[10:8], w[9:2]};
                cy = 1'b0;
            end
            WT_ARITH: begin
                cy = 1'b0;
                exec_register_op(w[9:2]);
            end
            default: begin
                if (!cy) pc = {pc[10:8], w[9:2]};
                cy = 1'b0;
            end
        endcase
        o.fetch = pc;
        o.carry = cy;
        o.disp = disp_on;
        o.reg_a = regs[REG_A];
        o.reg_b = regs[REG_B];
        o.status = bad;
        return o;
    endfunction

    function automatic logic [9:0] grp_word(logic [3:0] n, logic [1:0] sub, logic [1:0] grp);
        return {n, sub, grp, WT_MISC};
    endfunction

    function automatic logic [9:0] reg_word(arith_op_t op, logic [2:0] ws);
        return {op, ws, WT_ARITH};
    endfunction

    function automatic void add_row(logic [9:0] w, logic key, logic [7:0] code, bit typed,
                                    logic [10:0] t_fetch, logic t_status);
        stim_row_t r;
        r.word = w;
        r.key = key;
        r.code = code;
        r.typed = typed;
        r.t_fetch = t_fetch;
        r.t_status = t_status;
        directed.push_back(r);
    endfunction

    // Random instruction with a mix weighted toward register work on real digits.
    function automatic logic [9:0] random_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return reg_word(arith_op_t'($urandom_range(0, 31)),
                                        3'($urandom_range(0, 7)));
            4: return grp_word(4'($urandom_range(0, 9)), DOP_CONST, GRP_DATA);
            5: return grp_word(4'($urandom), 2'($urandom), GRP_POINTER);
            6: return 10'($urandom);
            7: return grp_word(4'($urandom_range(0, 12)), 2'($urandom), GRP_FLAGS);
            8: return grp_word(4'($urandom), 2'($urandom_range(2, 3)), GRP_DATA);
            default: return {6'($urandom), GRP_MISC, WT_MISC};
        endcase
    endfunction

    // Offers one item and waits for it to be accepted, then predicts its result.
    task automatic send_item(logic [9:0] w, logic key, logic [7:0] code, int gap, bit typed,
                             logic [10:0] t_fetch, logic t_status);
        outcome_t o;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_instruction <= w;
        s_key_pressed <= key;
        s_key_code <= code;
        do @(posedge aclk); while (!s_ready);
        o = execute_word(w, key, code);
        if (typed) begin
            o.fetch = t_fetch;
            o.status = t_status;
        end
        pending_results.push_back(o);
    endtask

    // Stimulus: directed rows, then random items.
    initial begin
        int gap;
        clear_state();
        // Reset state first: a plain word just steps the fetch address.
        add_row(10'h000, 1'b0, 8'h00, 1, 11'd1, 1'b0);
        add_row(grp_word(4'd13, POP_LOAD, GRP_POINTER), 1'b1, 8'hFF, 0, '0, 0);
        add_row(grp_word(4'd9, DOP_CONST, GRP_DATA), 1'b0, 8'h00, 0, '0, 0);
        add_row(grp_word(4'd15, POP_LOAD, GRP_POINTER), 1'b0, 8'h00, 0, '0, 0);
        // Constant with the pointer past the top digit writes nothing.
        add_row(grp_word(4'd7, DOP_CONST, GRP_DATA), 1'b0, 8'h00, 0, '0, 0);
        add_row(grp_word(4'd0, POP_INC, GRP_POINTER), 1'b0, 8'h00, 0, '0, 0);
        add_row(grp_word(4'd0, POP_DEC, GRP_POINTER), 1'b0, 8'h00, 0, '0, 0);
        add_row(grp_word(4'd10, DOP_CONST, GRP_DATA), 1'b0, 8'h00, 1, 11'd8, 1'b1);
        add_row(reg_word(AR_MOV_A_C, WS_WORD), 1'b0, 8'h00, 0, '0, 0);
        add_row(reg_word(AR_NEG9_C, WS_WORD), 1'b0, 8'h00, 0, '0, 0);
        add_row(reg_word(AR_DEC_A, WS_EXP), 1'b0, 8'h00, 0, '0, 0);
        add_row(reg_word(AR_XCH_A_B, WS_UPTO_P), 1'b0, 8'h00, 0, '0, 0);
        add_row(reg_word(AR_SHL_A, WS_SIGN), 1'b0, 8'h00, 0, '0, 0);
        add_row(grp_word(4'd11, FOP_SET, GRP_FLAGS), 1'b0, 8'h00, 0, '0, 0);
        add_row(grp_word(4'd11, FOP_TEST, GRP_FLAGS), 1'b0, 8'h00, 0, '0, 0);
        add_row(grp_word(4'd12, FOP_SET, GRP_FLAGS), 1'b0, 8'h00, 1, 11'd16, 1'b1);
        add_row(grp_word(4'd1, FOP_CLALL, GRP_FLAGS), 1'b0, 8'h00, 1, 11'd17, 1'b1);
        add_row(grp_word(4'd0, DOP_UNUSED, GRP_DATA), 1'b0, 8'h00, 1, 11'd18, 1'b1);
        add_row(grp_word(DN_DISP_TOGGLE, 2'd2, GRP_DATA), 1'b0, 8'h00, 0, '0, 0);
        add_row({3'd4, MOP_STORE, 1'b1, GRP_MISC, WT_MISC}, 1'b0, 8'h00, 0, '0, 0);
        add_row({MN_STORE_WR, MOP_STORE, 1'b1, GRP_MISC, WT_MISC}, 1'b0, 8'h00, 0, '0, 0);
        add_row({8'hC3, WT_CALL}, 1'b1, 8'h00, 0, '0, 0);
        add_row({3'd7, MOP_ROM_SEL, 1'b1, GRP_MISC, WT_MISC}, 1'b0, 8'h00, 0, '0, 0);
        add_row({3'd1, MOP_KEY_JUMP, 1'b1, GRP_MISC, WT_MISC}, 1'b0, 8'hFF, 0, '0, 0);
        add_row(10'h3FF, 1'b1, 8'hFF, 0, '0, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_item(directed[i].word, directed[i].key, directed[i].code,
                      $urandom_range(0, 16), directed[i].typed, directed[i].t_fetch,
                      directed[i].t_status);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // A stretch in the middle runs back to back.
            gap = (i >= 150 && i < 220) ? 0 : $urandom_range(0, 16);
            send_item(random_word(), 1'($urandom), 8'($urandom), gap, 0, '0, 0);
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Result side: random stalls, one long hold-off, and in-order checking.
    initial begin
        int stall;
        outcome_t e;
        wait (aresetn);
        forever begin
            if (results_seen == 60) stall = HOLD_CYCLES;
            else if (results_seen >= 250 && results_seen < 320) stall = 0;
            else stall = $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = pending_results.pop_front();
                if (m_fetch_address !== e.fetch || m_carry_flag !== e.carry ||
                    m_display_enabled !== e.disp || m_reg_a_digits !== e.reg_a ||
                    m_reg_b_digits !== e.reg_b || m_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch %0d: exp pc %h cy %b disp %b st %b a %h b %h",
                                 results_seen, e.fetch, e.carry, e.disp, e.status,
                                 e.reg_a, e.reg_b);
                        $display("             got pc %h cy %b disp %b st %b a %h b %h",
                                 m_fetch_address, m_carry_flag, m_display_enabled,
                                 m_status, m_reg_a_digits, m_reg_b_digits);
                    end
                end
            end
        end
    end

    // End of run: drain, allow the block's latency to pass, then report.
    initial begin
        wait (stimulus_done);
        wait (pending_results.size() == 0);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
